FILE: hw/rtl/rc4d_pkg.sv
// rc4d_pkg: shared types, codes and constants of the RC4-drop stream cipher.
// Used by rc4d_ctrl, rc4d_datapath and rc4_drop_stream_cipher; no dependencies.
`timescale 1ns / 1ps
package rc4d_pkg;

  localparam int PERM_SIZE             = 256;
  localparam int KEY_WORDS             = 4;
  localparam int KEY_WORD_W            = 64;
  localparam int MAX_KEY_BYTES_DEFAULT = 32;
  localparam int CFG_INDEX_W           = 3;

  localparam logic [5:0]  KEY_LENGTH_RESET = 6'd16;
  localparam logic [15:0] DROP_COUNT_RESET = 16'd768;

  // opcode field
  localparam logic OP_REKEY = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_DROP_COUNT = 3'd5;

  typedef logic [KEY_WORDS-1:0][KEY_WORD_W-1:0] rc4d_key_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] in_byte;
    logic       end_of_message;
  } rc4d_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } rc4d_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ_I,
    ST_READ_J,
    ST_SWAP
  } rc4d_state_e;

  typedef enum logic [1:0] {
    MODE_DATA,
    MODE_KSA,
    MODE_DROP
  } rc4d_mode_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic init;     // identity permutation, i = -1, j = 0, key index 0
    logic rd_i;     // advance i, read S[i]
    logic rd_j;     // capture S[i], advance j, read S[j]
    logic ksa;      // add key byte in the j update
    logic swap;     // write S[i] = S[j], read S[S[i] + S[j]], queue S[j] write
    logic clr_idx;  // zero both indices
  } rc4d_cmd_t;

  typedef struct packed {
    logic i_last;   // i is at the last permutation entry
  } rc4d_stat_t;

endpackage

FILE: hw/rtl/rc4d_ctrl.sv
// rc4d_ctrl: sequencer for key schedule, keystream drop and data steps.
// Depends on rc4d_pkg; drives rc4d_datapath through rc4d_cmd_t.
`timescale 1ns / 1ps
module rc4d_ctrl
  import rc4d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        opcode_i,
  input  logic        out_free_i,
  input  logic [15:0] drop_count_i,
  input  rc4d_stat_t  stat_i,
  output logic        in_ready_o,
  output logic        accept_o,
  output logic        load_out_o,
  output rc4d_cmd_t   cmd_o
);

  rc4d_state_e state_q, state_d;
  rc4d_mode_e  mode_q, mode_d;
  logic [15:0] cnt_q, cnt_d;
  logic        ks_pend_q, ks_pend_d;
  logic        stall;

  // a finished keystream byte waits in the read register until the output takes it
  assign stall      = ks_pend_q && !out_free_i;
  assign in_ready_o = (state_q == ST_IDLE) && !stall;
  assign accept_o   = in_valid_i && in_ready_o;
  assign load_out_o = (state_q == ST_IDLE) && ks_pend_q && out_free_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept_o) begin
          state_d = (opcode_i == OP_DATA) ? ST_READ_J : ST_READ_I;
        end
      end
      ST_READ_I: state_d = ST_READ_J;
      ST_READ_J: state_d = ST_SWAP;
      ST_SWAP: begin
        unique case (mode_q)
          MODE_DATA: state_d = ST_IDLE;
          MODE_KSA: begin
            if (!stat_i.i_last) begin
              state_d = ST_READ_I;
            end else begin
              state_d = (drop_count_i == '0) ? ST_IDLE : ST_READ_I;
            end
          end
          MODE_DROP: state_d = (cnt_q == 16'd1) ? ST_IDLE : ST_READ_I;
          default:   state_d = ST_IDLE;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    mode_d    = mode_q;
    cnt_d     = cnt_q;
    ks_pend_d = ks_pend_q;
    if (load_out_o) begin
      ks_pend_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept_o) begin
          if (opcode_i == OP_DATA) begin
            cmd_o.rd_i = 1'b1;
            mode_d     = MODE_DATA;
          end else begin
            cmd_o.init = 1'b1;
            mode_d     = MODE_KSA;
          end
        end
      end
      ST_READ_I: cmd_o.rd_i = 1'b1;
      ST_READ_J: begin
        cmd_o.rd_j = 1'b1;
        cmd_o.ksa  = (mode_q == MODE_KSA);
      end
      ST_SWAP: begin
        cmd_o.swap = 1'b1;
        unique case (mode_q)
          MODE_DATA: ks_pend_d = 1'b1;
          MODE_KSA: begin
            if (stat_i.i_last) begin
              cmd_o.clr_idx = 1'b1;
              mode_d        = MODE_DROP;
              cnt_d         = drop_count_i;
            end
          end
          MODE_DROP: cnt_d = cnt_q - 16'd1;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mode_q    <= MODE_DATA;
      cnt_q     <= '0;
      ks_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      cnt_q     <= cnt_d;
      ks_pend_q <= ks_pend_d;
    end
  end

endmodule

FILE: hw/rtl/rc4d_datapath.sv
// rc4d_datapath: permutation memory, indices, key byte select and keystream output.
// Depends on rc4d_pkg; commanded by rc4d_ctrl.
`timescale 1ns / 1ps
module rc4d_datapath
  import rc4d_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rc4d_cmd_t  cmd_i,
  input  rc4d_key_t  key_i,
  input  logic [5:0] key_length_i,
  output rc4d_stat_t stat_o,
  output logic [7:0] ks_o
);

  localparam int          KIDX_W    = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [8:0]  MAX_LEN   = 9'(MAX_KEY_BYTES);
  localparam logic [8:0]  KEY_BYTES = 9'(KEY_WORDS * 8);

  logic [7:0]          mem_q [PERM_SIZE];
  logic [PERM_SIZE-1:0] valid_q;
  logic [7:0]          rdata_q;

  logic [7:0] i_q, j_q, si_q, t_q;
  logic [7:0] pend_addr_q, pend_data_q;
  logic       pend_q;
  logic [KIDX_W-1:0] kidx_q;

  logic       we, re;
  logic [7:0] waddr, wdata, raddr;
  logic [7:0] i_next, j_next, t_next, key_byte;
  logic [8:0] len_ext, len_eff, kidx_ext;

  // key byte of the current schedule position; positions past the key words read 0
  assign len_ext  = {3'b000, key_length_i};
  assign kidx_ext = 9'(kidx_q);

  always_comb begin
    len_eff = len_ext;
    if (len_ext == '0) begin
      len_eff = 9'd1;
    end else if (len_ext > MAX_LEN) begin
      len_eff = MAX_LEN;
    end
  end

  always_comb begin
    key_byte = '0;
    if (kidx_ext < KEY_BYTES) begin
      key_byte = key_i[kidx_ext[4:3]][{kidx_ext[2:0], 3'b000} +: 8];
    end
  end

  assign i_next = i_q + 8'd1;
  assign j_next = j_q + rdata_q + (cmd_i.ksa ? key_byte : 8'd0);
  assign t_next = si_q + rdata_q;

  // one write port: queued S[j] write, or S[i] = S[j] during the swap
  always_comb begin
    we    = pend_q || cmd_i.swap;
    waddr = pend_q ? pend_addr_q : i_q;
    wdata = pend_q ? pend_data_q : rdata_q;
    re    = cmd_i.rd_i || cmd_i.rd_j || cmd_i.swap;
    raddr = i_next;
    if (cmd_i.rd_j) begin
      raddr = j_next;
    end else if (cmd_i.swap) begin
      raddr = t_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  // entries not written since the last rekey read as the identity
  always_ff @(posedge clk_i) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata_q <= wdata;
      end else if (valid_q[raddr]) begin
        rdata_q <= mem_q[raddr];
      end else begin
        rdata_q <= raddr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.init) begin
      valid_q <= '0;
    end else if (we) begin
      valid_q[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q    <= '0;
      j_q    <= '0;
      kidx_q <= '0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.swap;
      if (cmd_i.init) begin
        i_q    <= '1;
        j_q    <= '0;
        kidx_q <= '0;
      end else if (cmd_i.clr_idx) begin
        i_q <= '0;
        j_q <= '0;
      end else begin
        if (cmd_i.rd_i) begin
          i_q <= i_next;
        end
        if (cmd_i.rd_j) begin
          j_q <= j_next;
        end
        if (cmd_i.ksa) begin
          kidx_q <= (kidx_ext == len_eff - 9'd1) ? '0 : kidx_q + KIDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_j) begin
      si_q <= rdata_q;
    end
    if (cmd_i.swap) begin
      t_q         <= t_next;
      pend_addr_q <= j_q;
      pend_data_q <= si_q;
    end
  end

  // the S[j] write is queued behind the S[t] read; forward S[i] when the output index hits j
  assign ks_o          = (t_q == j_q) ? si_q : rdata_q;
  assign stat_o.i_last = (i_q == 8'hFF);

endmodule

FILE: hw/rtl/rc4_drop_stream_cipher.sv
// rc4_drop_stream_cipher: top level with configuration registers and output register.
// Depends on rc4d_pkg, rc4d_ctrl and rc4d_datapath.
`timescale 1ns / 1ps
// RC4-drop stream cipher. Write the key words, key_length and drop_count on the
// configuration port (always ready), then send a rekey beat (opcode 0): it runs the
// 256-step key schedule and discards drop_count keystream bytes, giving no output
// beat. Each data beat (opcode 1) returns in_byte XOR the next keystream byte, with
// end_of_message copied to out_last; the same operation encrypts and decrypts.
// Register writes take effect at the next rekey if made while no rekey runs; the
// block itself does not enforce this. Data sent before any rekey runs on the
// identity permutation. A data beat's result enters the output register in the
// cycle in which the next beat may already be accepted. A rekey runs the key
// schedule, then drop_count generator steps, both paced by the single-write-port
// permutation memory: each generator step reads S[i], S[j] and S[S[i] + S[j]] in
// turn and writes the two swapped entries, the second write overlapping the next
// step's first read.
module rc4_drop_stream_cipher
  import rc4d_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [KEY_WORD_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  rc4d_in_t               in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rc4d_out_t              out_data_o
);

  rc4d_key_t   key_q;
  logic [5:0]  key_length_q;
  logic [15:0] drop_count_q;

  logic [7:0]  in_byte_q;
  logic        eom_q;
  logic        out_valid_q;
  rc4d_out_t   out_q;

  rc4d_cmd_t   cmd;
  rc4d_stat_t  stat;
  logic        accept, load_out, out_free;
  logic [7:0]  ks;

  // Configuration: always accept a beat; unused indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q        <= '0;
      key_length_q <= KEY_LENGTH_RESET;
      drop_count_q <= DROP_COUNT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i) inside
        CFG_KEY_WORD_0, CFG_KEY_WORD_1, CFG_KEY_WORD_2, CFG_KEY_WORD_3: begin
          key_q[cfg_index_i[1:0]] <= cfg_data_i;
        end
        CFG_KEY_LENGTH: key_length_q <= cfg_data_i[5:0];
        CFG_DROP_COUNT: drop_count_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Output register: take a new result when empty or when the current beat leaves.
  assign out_free = !out_valid_q || out_ready_i;

  rc4d_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .opcode_i     (in_data_i.opcode),
    .out_free_i   (out_free),
    .drop_count_i (drop_count_q),
    .stat_i       (stat),
    .in_ready_o   (in_ready_o),
    .accept_o     (accept),
    .load_out_o   (load_out),
    .cmd_o        (cmd)
  );

  rc4d_datapath #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .key_i        (key_q),
    .key_length_i (key_length_q),
    .stat_o       (stat),
    .ks_o         (ks)
  );

  // Hold the data byte and its last-byte mark while the keystream byte is produced.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= in_data_i.in_byte;
      eom_q     <= in_data_i.end_of_message;
    end
    if (load_out) begin
      out_q.out_byte <= in_byte_q ^ ks;
      out_q.out_last <= eom_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
